### hdl/bfa_pkg.sv
// Shared types and constants for the best-fit heap allocator.
// Used by the controller and the datapath; no dependencies.
`timescale 1ns / 1ps

package bfa_pkg;

  localparam logic       OPC_ALLOC = 1'b0;
  localparam logic       OPC_FREE  = 1'b1;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_ZERO    = 3'd1;
  localparam logic [2:0] ST_OOM     = 3'd2;
  localparam logic [2:0] ST_INVALID = 3'd3;
  localparam logic [2:0] ST_DFREE   = 3'd4;

  localparam int unsigned MIN_BLOCK_BYTES   = 32;
  localparam int unsigned MIN_PAYLOAD_BYTES = 16;
  localparam int unsigned ALIGN_MASK        = 7;
  localparam logic [15:0] LIMIT_RESET       = 16'd32768;

  typedef enum logic [5:0] {
    OP_NOP, OP_LOAD, OP_A_START, OP_W_RD, OP_W_SZ, OP_W_LN, OP_ARG_BEST,
    OP_A_GROW, OP_A_SPLIT, OP_A_SS_FINAL, OP_SS_HDR, OP_SS_FTR, OP_FINISH,
    OP_F_CHECK, OP_F_HDR, OP_F_RCHK, OP_F_RNS, OP_ARG_HW, OP_F_LCHK,
    OP_F_LPS, OP_F_LMRG, OP_F_TOP, OP_F_SHRINK,
    OP_I_START, OP_I_E2, OP_I_RT, OP_I_TL, OP_I_W2, OP_I_W3, OP_I_W4,
    OP_U_R1, OP_U_R2, OP_U_R3, OP_U_W1, OP_U_W2
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [2:0] code;
  } cmd_t;

  typedef struct packed {
    logic is_free;
    logic req_zero;
    logic empty;
    logic walk_more;
    logic found;
    logic oom;
    logic split;
    logic bad_ptr;
    logic dfree;
    logic bad_size;
    logic right_in;
    logic right_free;
    logic hw_pos;
    logic rmerged;
    logic left_free;
    logic merged;
    logic at_top;
    logic self_link;
    logic out_busy;
  } sts_t;

endpackage

### hdl/bfa_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module bfa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### hdl/bfa_datapath.sv
// Allocator datapath: heap memory, list and heap registers, result register.
// Depends on bfa_pkg and bfa_ram; driven by bfa_ctrl commands.
`timescale 1ns / 1ps

module bfa_datapath #(
  parameter int HEAP_WORDS = 4096
) (
  input  logic          clk,
  input  logic          rst,
  input  bfa_pkg::cmd_t cmd,
  output bfa_pkg::sts_t sts,
  input  logic          cfg_valid,
  input  logic [15:0]   cfg_data,
  input  logic          opcode,
  input  logic [15:0]   request_bytes,
  input  logic [14:0]   payload_address,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [2:0]    status,
  output logic [14:0]   granted_address,
  output logic [15:0]   granted_bytes
);
  import bfa_pkg::*;

  localparam int AW = $clog2(HEAP_WORDS);
  localparam int SW = $clog2(HEAP_WORDS + 1);
  localparam int unsigned HEAP_BYTES = HEAP_WORDS * 8;

  logic [15:0]   limit;
  logic [15:0]   top;
  logic [AW-1:0] head;
  logic          empty;
  logic          opc;
  logic [15:0]   req;
  logic [14:0]   paddr;
  logic [17:0]   need;
  logic [AW-1:0] best;
  logic [63:0]   bsize;
  logic          found;
  logic [AW-1:0] w;
  logic [SW-1:0] steps;
  logic [AW-1:0] hw;
  logic [63:0]   size;
  logic [63:0]   ps;
  logic          merged;
  logic          rmerged;
  logic [AW-1:0] arg;
  logic [AW-1:0] nx;
  logic [AW-1:0] pv;
  logic [AW-1:0] ss_addr;
  logic [63:0]   ss_val;

  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [63:0]   ram_wdata;
  logic [63:0]   rdata;

  logic [15:0]   req_min;
  logic [17:0]   need_calc;
  logic [AW-1:0] link;
  logic [63:0]   rest;
  logic [63:0]   hwb;
  logic [63:0]   hsize;
  logic [31:0]   eff_limit;
  logic [AW-1:0] lw;
  logic          out_take;

  bfa_ram #(.WIDTH(64), .DEPTH(HEAP_WORDS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (rdata)
  );

  assign req_min   = (req < 16'(MIN_PAYLOAD_BYTES)) ? 16'(MIN_PAYLOAD_BYTES) : req;
  assign need_calc = 18'(MIN_PAYLOAD_BYTES)
                   + ((18'(req_min) + 18'(ALIGN_MASK)) & ~18'(ALIGN_MASK));
  assign link      = rdata[AW-1:0];
  assign rest      = bsize - 64'(need);
  assign hwb       = 64'(hw) << 3;
  assign hsize     = rdata & ~64'd1;
  assign eff_limit = (32'(limit) < HEAP_BYTES) ? 32'(limit) : HEAP_BYTES;
  assign lw        = hw - AW'(ps >> 3);
  assign out_take  = out_valid && out_ready;

  always_comb begin
    sts.is_free    = opc;
    sts.req_zero   = (req == 16'd0);
    sts.empty      = empty;
    sts.walk_more  = (link != head) && ((32'(steps) + 32'd1) < 32'(HEAP_WORDS));
    sts.found      = found;
    sts.oom        = (32'(top) + 32'(need)) > eff_limit;
    sts.split      = rest >= 64'(MIN_BLOCK_BYTES);
    sts.bad_ptr    = (paddr == 15'd0) || (paddr[2:0] != 3'd0) || (16'(paddr) >= top);
    sts.dfree      = !rdata[0];
    sts.bad_size   = (hsize < 64'(MIN_BLOCK_BYTES)) || (hsize[2:0] != 3'd0)
                   || (hsize > (64'(top) - hwb));
    sts.right_in   = (hwb + size) < 64'(top);
    sts.right_free = !rdata[0];
    sts.hw_pos     = (hw != '0);
    sts.rmerged    = rmerged;
    sts.left_free  = !ps[0];
    sts.merged     = merged;
    sts.at_top     = (hwb + size) == 64'(top);
    sts.self_link  = (nx == arg);
    sts.out_busy   = out_valid && !out_ready;
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = w;
    ram_wdata = 64'(arg);
    case (cmd.op)
      OP_W_RD:    ram_addr = w;
      OP_W_SZ:    ram_addr = w + AW'(1);
      OP_W_LN:    ram_addr = link;
      OP_SS_HDR: begin
        ram_we    = 1'b1;
        ram_addr  = ss_addr;
        ram_wdata = ss_val;
      end
      OP_SS_FTR: begin
        ram_we    = 1'b1;
        ram_addr  = ss_addr + AW'(ss_val >> 3) - AW'(1);
        ram_wdata = ss_val;
      end
      OP_F_CHECK: ram_addr = AW'(paddr >> 3) - AW'(1);
      OP_F_RCHK:  ram_addr = hw + AW'(size >> 3);
      OP_F_LCHK:  ram_addr = hw - AW'(1);
      OP_I_START: begin
        ram_we    = empty;
        ram_addr  = arg + AW'(1);
        ram_wdata = 64'(arg);
      end
      OP_I_E2: begin
        ram_we    = 1'b1;
        ram_addr  = arg + AW'(2);
        ram_wdata = 64'(arg);
      end
      OP_I_RT:    ram_addr = head + AW'(2);
      OP_I_TL: begin
        ram_we    = 1'b1;
        ram_addr  = arg + AW'(1);
        ram_wdata = 64'(head);
      end
      OP_I_W2: begin
        ram_we    = 1'b1;
        ram_addr  = arg + AW'(2);
        ram_wdata = 64'(pv);
      end
      OP_I_W3: begin
        ram_we    = 1'b1;
        ram_addr  = pv + AW'(1);
        ram_wdata = 64'(arg);
      end
      OP_I_W4: begin
        ram_we    = 1'b1;
        ram_addr  = head + AW'(2);
        ram_wdata = 64'(arg);
      end
      OP_U_R1:    ram_addr = arg + AW'(1);
      OP_U_R2:    ram_addr = arg + AW'(2);
      OP_U_W1: begin
        ram_we    = 1'b1;
        ram_addr  = pv + AW'(1);
        ram_wdata = 64'(nx);
      end
      OP_U_W2: begin
        ram_we    = 1'b1;
        ram_addr  = nx + AW'(2);
        ram_wdata = 64'(pv);
      end
      default: ram_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limit     <= LIMIT_RESET;
      top       <= 16'd0;
      head      <= '0;
      empty     <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        limit <= cfg_data;
      end
      if (out_take) begin
        out_valid <= 1'b0;
      end
      case (cmd.op)
        OP_LOAD: begin
          opc     <= opcode;
          req     <= request_bytes;
          paddr   <= payload_address;
          found   <= 1'b0;
          merged  <= 1'b0;
          rmerged <= 1'b0;
        end
        OP_A_START: begin
          need  <= need_calc;
          w     <= head;
          steps <= '0;
        end
        OP_W_SZ: begin
          if ((rdata >= 64'(need)) && (!found || (rdata < bsize))) begin
            found <= 1'b1;
            best  <= w;
            bsize <= rdata;
          end
        end
        OP_W_LN: begin
          w     <= link;
          steps <= steps + SW'(1);
        end
        OP_ARG_BEST: arg <= best;
        OP_A_GROW: begin
          if (!sts.oom) begin
            best <= AW'(top >> 3);
            top  <= 16'(32'(top) + 32'(need));
          end
        end
        OP_A_SPLIT: begin
          if (sts.split) begin
            ss_addr <= best + AW'(need >> 3);
            ss_val  <= rest;
            arg     <= best + AW'(need >> 3);
          end else begin
            need <= 18'(bsize);
          end
        end
        OP_A_SS_FINAL: begin
          ss_addr <= best;
          ss_val  <= 64'(need) | 64'd1;
        end
        OP_FINISH: begin
          out_valid <= 1'b1;
          status    <= cmd.code;
          if ((cmd.code == ST_OK) && (opc == OPC_ALLOC)) begin
            granted_address <= 15'((32'(best) << 3) + 32'd8);
            granted_bytes   <= need[15:0];
          end else begin
            granted_address <= 15'd0;
            granted_bytes   <= 16'd0;
          end
        end
        OP_F_CHECK: hw <= AW'(paddr >> 3) - AW'(1);
        OP_F_HDR: begin
          size    <= hsize;
          ss_addr <= hw;
          ss_val  <= hsize;
        end
        OP_F_RCHK: arg <= hw + AW'(size >> 3);
        OP_F_RNS: begin
          if (sts.right_free) begin
            merged  <= 1'b1;
            size    <= rdata + size;
            ss_addr <= hw;
            ss_val  <= rdata + size;
          end
        end
        OP_ARG_HW: arg <= hw;
        OP_F_LCHK: begin
          arg     <= hw;
          rmerged <= merged;
        end
        OP_F_LPS: ps <= rdata;
        OP_F_LMRG: begin
          if (sts.left_free) begin
            merged  <= 1'b1;
            ss_addr <= lw;
            ss_val  <= ps + size;
            size    <= ps + size;
            hw      <= lw;
          end
        end
        OP_F_TOP: arg <= hw;
        OP_F_SHRINK: top <= top - size[15:0];
        OP_I_E2: begin
          empty <= 1'b0;
          head  <= arg;
        end
        OP_I_TL: pv <= link;
        OP_I_W4: head <= arg;
        OP_U_R2: nx <= link;
        OP_U_R3: begin
          pv <= link;
          if (nx == arg) begin
            empty <= 1'b1;
            head  <= '0;
          end else if (head == arg) begin
            head <= nx;
          end
        end
        default: ;
      endcase
    end
  end

  a_fail_no_grant: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != ST_OK)) |-> (granted_address == 15'd0 && granted_bytes == 16'd0))
    else $error("failed request carries a grant");

  a_grant_aligned: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (granted_address[2:0] == 3'd0))
    else $error("granted address not word aligned");

  a_empty_head: assert property (@(posedge clk) disable iff (rst)
    empty |-> (head == '0))
    else $error("empty free list with non-zero head");

endmodule

### hdl/bfa_ctrl.sv
// Allocator controller: sequences the datapath through alloc and free,
// with shared set-size, list insert and list unlink routines. Depends on bfa_pkg.
`timescale 1ns / 1ps

module bfa_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  bfa_pkg::sts_t sts,
  output bfa_pkg::cmd_t cmd
);
  import bfa_pkg::*;

  localparam int NS = 38;

  typedef enum logic [NS-1:0] {
    S_IDLE     = NS'(1) << 0,  S_DISPATCH = NS'(1) << 1,  S_A_START  = NS'(1) << 2,
    S_W_RD     = NS'(1) << 3,  S_W_SZ     = NS'(1) << 4,  S_W_LN     = NS'(1) << 5,
    S_A_SEL    = NS'(1) << 6,  S_A_GROW   = NS'(1) << 7,  S_A_SPLIT  = NS'(1) << 8,
    S_A_INS    = NS'(1) << 9,  S_A_FIN    = NS'(1) << 10, S_SS_HDR   = NS'(1) << 11,
    S_SS_FTR   = NS'(1) << 12, S_DONE     = NS'(1) << 13, S_F_CHECK  = NS'(1) << 14,
    S_F_HDR    = NS'(1) << 15, S_F_RCHK   = NS'(1) << 16, S_F_RNS    = NS'(1) << 17,
    S_F_RUNL   = NS'(1) << 18, S_F_RINS   = NS'(1) << 19, S_F_LCHK   = NS'(1) << 20,
    S_F_LPS    = NS'(1) << 21, S_F_LMRG   = NS'(1) << 22, S_F_TAIL   = NS'(1) << 23,
    S_F_TOP    = NS'(1) << 24, S_F_SHRINK = NS'(1) << 25, S_I_START  = NS'(1) << 26,
    S_I_E2     = NS'(1) << 27, S_I_RT     = NS'(1) << 28, S_I_TL     = NS'(1) << 29,
    S_I_W2     = NS'(1) << 30, S_I_W3     = NS'(1) << 31, S_I_W4     = NS'(1) << 32,
    S_U_R1     = NS'(1) << 33, S_U_R2     = NS'(1) << 34, S_U_R3     = NS'(1) << 35,
    S_U_W1     = NS'(1) << 36, S_U_W2     = NS'(1) << 37
  } state_t;

  state_t     state, state_next;
  state_t     ret, ret_next;
  logic [2:0] code, code_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    ret_next   = ret;
    code_next  = code;
    cmd.op     = OP_NOP;
    cmd.code   = code;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: state_next = sts.is_free ? S_F_CHECK : S_A_START;
      S_A_START: begin
        cmd.op = OP_A_START;
        if (sts.req_zero) begin
          code_next  = ST_ZERO;
          state_next = S_DONE;
        end else if (sts.empty) begin
          state_next = S_A_GROW;
        end else begin
          state_next = S_W_RD;
        end
      end
      S_W_RD: begin
        cmd.op     = OP_W_RD;
        state_next = S_W_SZ;
      end
      S_W_SZ: begin
        cmd.op     = OP_W_SZ;
        state_next = S_W_LN;
      end
      S_W_LN: begin
        cmd.op     = OP_W_LN;
        state_next = sts.walk_more ? S_W_SZ : S_A_SEL;
      end
      S_A_SEL: begin
        cmd.op = OP_ARG_BEST;
        if (sts.found) begin
          ret_next   = S_A_SPLIT;
          state_next = S_U_R1;
        end else begin
          state_next = S_A_GROW;
        end
      end
      S_A_GROW: begin
        cmd.op = OP_A_GROW;
        if (sts.oom) begin
          code_next  = ST_OOM;
          state_next = S_DONE;
        end else begin
          state_next = S_A_FIN;
        end
      end
      S_A_SPLIT: begin
        cmd.op = OP_A_SPLIT;
        if (sts.split) begin
          ret_next   = S_A_INS;
          state_next = S_SS_HDR;
        end else begin
          state_next = S_A_FIN;
        end
      end
      S_A_INS: begin
        ret_next   = S_A_FIN;
        state_next = S_I_START;
      end
      S_A_FIN: begin
        cmd.op     = OP_A_SS_FINAL;
        code_next  = ST_OK;
        ret_next   = S_DONE;
        state_next = S_SS_HDR;
      end
      S_SS_HDR: begin
        cmd.op     = OP_SS_HDR;
        state_next = S_SS_FTR;
      end
      S_SS_FTR: begin
        cmd.op     = OP_SS_FTR;
        state_next = ret;
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.op     = OP_FINISH;
          state_next = S_IDLE;
        end
      end
      S_F_CHECK: begin
        cmd.op = OP_F_CHECK;
        if (sts.bad_ptr) begin
          code_next  = ST_INVALID;
          state_next = S_DONE;
        end else begin
          state_next = S_F_HDR;
        end
      end
      S_F_HDR: begin
        cmd.op = OP_F_HDR;
        if (sts.dfree) begin
          code_next  = ST_DFREE;
          state_next = S_DONE;
        end else if (sts.bad_size) begin
          code_next  = ST_INVALID;
          state_next = S_DONE;
        end else begin
          ret_next   = S_F_RCHK;
          state_next = S_SS_HDR;
        end
      end
      S_F_RCHK: begin
        cmd.op     = OP_F_RCHK;
        state_next = sts.right_in ? S_F_RNS : S_F_LCHK;
      end
      S_F_RNS: begin
        cmd.op = OP_F_RNS;
        if (sts.right_free) begin
          ret_next   = S_F_RUNL;
          state_next = S_SS_HDR;
        end else begin
          state_next = S_F_LCHK;
        end
      end
      S_F_RUNL: begin
        ret_next   = S_F_RINS;
        state_next = S_U_R1;
      end
      S_F_RINS: begin
        cmd.op     = OP_ARG_HW;
        ret_next   = S_F_LCHK;
        state_next = S_I_START;
      end
      S_F_LCHK: begin
        cmd.op     = OP_F_LCHK;
        state_next = sts.hw_pos ? S_F_LPS : S_F_TAIL;
      end
      S_F_LPS: begin
        cmd.op = OP_F_LPS;
        if (sts.rmerged) begin
          ret_next   = S_F_LMRG;
          state_next = S_U_R1;
        end else begin
          state_next = S_F_LMRG;
        end
      end
      S_F_LMRG: begin
        cmd.op = OP_F_LMRG;
        if (sts.left_free) begin
          ret_next   = S_F_TAIL;
          state_next = S_SS_HDR;
        end else if (sts.rmerged) begin
          ret_next   = S_F_TAIL;
          state_next = S_I_START;
        end else begin
          state_next = S_F_TAIL;
        end
      end
      S_F_TAIL: begin
        cmd.op = OP_ARG_HW;
        if (!sts.merged) begin
          ret_next   = S_F_TOP;
          state_next = S_I_START;
        end else begin
          state_next = S_F_TOP;
        end
      end
      S_F_TOP: begin
        cmd.op    = OP_F_TOP;
        code_next = ST_OK;
        if (sts.at_top) begin
          ret_next   = S_F_SHRINK;
          state_next = S_U_R1;
        end else begin
          state_next = S_DONE;
        end
      end
      S_F_SHRINK: begin
        cmd.op     = OP_F_SHRINK;
        state_next = S_DONE;
      end
      S_I_START: begin
        cmd.op     = OP_I_START;
        state_next = sts.empty ? S_I_E2 : S_I_RT;
      end
      S_I_E2: begin
        cmd.op     = OP_I_E2;
        state_next = ret;
      end
      S_I_RT: begin
        cmd.op     = OP_I_RT;
        state_next = S_I_TL;
      end
      S_I_TL: begin
        cmd.op     = OP_I_TL;
        state_next = S_I_W2;
      end
      S_I_W2: begin
        cmd.op     = OP_I_W2;
        state_next = S_I_W3;
      end
      S_I_W3: begin
        cmd.op     = OP_I_W3;
        state_next = S_I_W4;
      end
      S_I_W4: begin
        cmd.op     = OP_I_W4;
        state_next = ret;
      end
      S_U_R1: begin
        cmd.op     = OP_U_R1;
        state_next = S_U_R2;
      end
      S_U_R2: begin
        cmd.op     = OP_U_R2;
        state_next = S_U_R3;
      end
      S_U_R3: begin
        cmd.op     = OP_U_R3;
        state_next = sts.self_link ? ret : S_U_W1;
      end
      S_U_W1: begin
        cmd.op     = OP_U_W1;
        state_next = S_U_W2;
      end
      S_U_W2: begin
        cmd.op     = OP_U_W2;
        state_next = ret;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret   <= S_IDLE;
      code  <= ST_OK;
    end else begin
      state <= state_next;
      ret   <= ret_next;
      code  <= code_next;
    end
  end

  a_walk_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_W_RD) |-> !sts.empty)
    else $error("free list walk started on an empty list");

  a_done_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && sts.out_busy) |=> (state == S_DONE))
    else $error("result dropped while output register full");

endmodule

### hdl/best_fit_heap_allocator.sv
// Best-fit heap allocator with boundary tags and an explicit free list.
// Alloc takes the best fit from the free list, or grows the heap top when none fits or the list is empty.
// Free may merge with the right and left neighbours, repair the free list and shrink the top.
// One request at a time; an alloc walks the free list with two memory reads per node.
// Result held in an output register; a new request is taken once the previous one is done.
// Reset: synchronous; empty heap, empty free list, limit 32768; memory contents undefined.
`timescale 1ns / 1ps

module best_fit_heap_allocator #(
  parameter int HEAP_WORDS = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        opcode,
  input  logic [15:0] request_bytes,
  input  logic [14:0] payload_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [14:0] granted_address,
  output logic [15:0] granted_bytes
);
  import bfa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  bfa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bfa_datapath #(.HEAP_WORDS(HEAP_WORDS)) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_valid       (cfg_valid),
    .cfg_data        (cfg_data),
    .opcode          (opcode),
    .request_bytes   (request_bytes),
    .payload_address (payload_address),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .granted_address (granted_address),
    .granted_bytes   (granted_bytes)
  );

endmodule

### sim/alloc_scoreboard.sv
// Scoreboard for the best-fit heap allocator: a bit-accurate predictor of the
// heap, its free list and the limit register, plus the queue of expected grants.
// Depends on bfa_pkg for the opcode and status codes and the block size constants.
`timescale 1ns / 1ps

typedef struct {
  logic [2:0]  st;
  logic [14:0] ga;
  logic [15:0] gb;
} grant_t;

class alloc_scoreboard;
  localparam int unsigned NWORDS = 4096;

  longint unsigned heap[NWORDS];
  bit              written[NWORDS];
  int unsigned     top;
  int unsigned     head;
  bit              empty;
  int unsigned     limit;
  grant_t          grant_q[$];
  int              live[$];
  int              stale[$];
  int              mismatches;
  int              checked;
  int              status_count[8];

  function new();
    top   = 0;
    head  = 0;
    empty = 1;
    limit = 32768;
  endfunction

  function longint unsigned rd(longint unsigned w);
    return (w < NWORDS) ? heap[w] : 0;
  endfunction

  function void wr(longint unsigned w, longint unsigned v);
    if (w < NWORDS) begin
      heap[w]    = v;
      written[w] = 1;
    end
  endfunction

  function longint unsigned lnk(longint unsigned v);
    return v % NWORDS;
  endfunction

  function void set_size(longint unsigned hw, longint unsigned v);
    wr(hw, v);
    wr(hw + ((v & ~64'd1) >> 3) - 1, v);
  endfunction

  function void list_insert(longint unsigned b);
    longint unsigned hd, tl;
    if (empty) begin
      wr(b + 1, b);
      wr(b + 2, b);
      empty = 0;
    end else begin
      hd = head;
      tl = lnk(rd(hd + 2));
      wr(b + 1, hd);
      wr(b + 2, tl);
      wr(tl + 1, b);
      wr(hd + 2, b);
    end
    head = lnk(b);
  endfunction

  function void list_unlink(longint unsigned b);
    longint unsigned nx, pv;
    nx = lnk(rd(b + 1));
    pv = lnk(rd(b + 2));
    if (nx == b) begin
      empty = 1;
      head  = 0;
    end else begin
      if (head == b) head = nx;
      wr(pv + 1, nx);
      wr(nx + 2, pv);
    end
  endfunction

  function grant_t do_alloc(int unsigned req);
    grant_t          g;
    longint unsigned need, best, best_size, w, s, lim, rest;
    bit              found;
    int unsigned     steps;
    g = '{st: bfa_pkg::ST_OK, ga: '0, gb: '0};
    best = 0; best_size = 0; found = 0; steps = 0;
    if (req == 0) begin
      g.st = bfa_pkg::ST_ZERO;
      return g;
    end
    need = (req < bfa_pkg::MIN_PAYLOAD_BYTES) ? bfa_pkg::MIN_PAYLOAD_BYTES : req;
    need = 16 + ((need + bfa_pkg::ALIGN_MASK) & ~64'(bfa_pkg::ALIGN_MASK));
    if (!empty) begin
      w = head;
      do begin
        s = rd(w);
        if (s >= need && (!found || s < best_size)) begin
          found = 1;
          best = w;
          best_size = s;
        end
        w = lnk(rd(w + 1));
        steps++;
      end while (w != head && steps < NWORDS);
    end
    if (!found) begin
      lim = (limit > NWORDS * 8) ? NWORDS * 8 : limit;
      if (top + need > lim) begin
        g.st = bfa_pkg::ST_OOM;
        return g;
      end
      best = top >> 3;
      top = (top + need) & 16'hFFFF;
    end else begin
      list_unlink(best);
      rest = best_size - need;
      if (rest >= bfa_pkg::MIN_BLOCK_BYTES) begin
        set_size(best + (need >> 3), rest);
        list_insert(best + (need >> 3));
      end else begin
        need = best_size;
      end
    end
    set_size(best, need | 1);
    g.ga = 15'(best * 8 + 8);
    g.gb = 16'(need);
    return g;
  endfunction

  function grant_t do_free(int unsigned p);
    grant_t          g;
    longint unsigned hw, hdr, size, t, nw, ns, ps;
    bit              merged, rmerged;
    g = '{st: bfa_pkg::ST_OK, ga: '0, gb: '0};
    t = top;
    merged = 0;
    if (p == 0 || (p & bfa_pkg::ALIGN_MASK) != 0 || p >= t) begin
      g.st = bfa_pkg::ST_INVALID;
      return g;
    end
    hw  = (p >> 3) - 1;
    hdr = rd(hw);
    if (hdr[0] == 0) begin
      g.st = bfa_pkg::ST_DFREE;
      return g;
    end
    size = hdr & ~64'd1;
    if (size < bfa_pkg::MIN_BLOCK_BYTES || (size & bfa_pkg::ALIGN_MASK) != 0 ||
        size > t - hw * 8) begin
      g.st = bfa_pkg::ST_INVALID;
      return g;
    end
    set_size(hw, size);
    if (hw * 8 + size < t) begin
      nw = hw + (size >> 3);
      ns = rd(nw);
      if (ns[0] == 0) begin
        merged = 1;
        set_size(hw, ns + size);
        list_unlink(nw);
        list_insert(hw);
      end
      size = rd(hw);
    end
    rmerged = merged;
    if (hw > 0) begin
      ps = rd(hw - 1);
      if (rmerged) list_unlink(hw);
      if (ps[0] == 0) begin
        merged = 1;
        set_size(hw - (ps >> 3), ps + rd(hw));
        hw = hw - (ps >> 3);
      end else if (rmerged) begin
        list_insert(hw);
      end
      size = rd(hw);
    end
    if (!merged) list_insert(hw);
    if (hw * 8 + size == t) begin
      list_unlink(hw);
      top = (t - size) & 16'hFFFF;
    end
    return g;
  endfunction

  // a stale address is safe only if it cannot land on a live footer
  function bit stale_safe(int unsigned p);
    if (p >= top) return 1;
    return written[p / 8 - 1] && heap[p / 8 - 1][0] == 0;
  endfunction

  function void note_request(logic op, logic [15:0] req, logic [14:0] pa);
    grant_t g;
    if (op == bfa_pkg::OPC_ALLOC) begin
      g = do_alloc(req);
      if (g.st == bfa_pkg::ST_OK) live.push_back(g.ga);
    end else begin
      g = do_free(pa);
      if (g.st == bfa_pkg::ST_OK) begin
        foreach (live[i]) if (live[i] == pa) begin
          live.delete(i);
          break;
        end
        stale.push_back(pa);
        if (stale.size() > 64) void'(stale.pop_front());
      end
    end
    status_count[g.st]++;
    grant_q.push_back(g);
  endfunction

  function void check_grant(logic [2:0] st, logic [14:0] ga, logic [15:0] gb);
    grant_t e;
    checked++;
    if (grant_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: unexpected beat status=%0d addr=%0d bytes=%0d", $realtime, st, ga, gb);
      return;
    end
    e = grant_q.pop_front();
    if (st !== e.st || ga !== e.ga || gb !== e.gb) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: mismatch exp status=%0d addr=%0d bytes=%0d got %0d %0d %0d",
                 $realtime, e.st, e.ga, e.gb, st, ga, gb);
    end
  endfunction
endclass

### sim/tb.sv
// Testbench top for best_fit_heap_allocator: drives requests, limit writes and
// result back-pressure with random gaps, checks every beat against the scoreboard.
// Depends on bfa_pkg and alloc_scoreboard.sv.
`timescale 1ns / 1ps

module tb;
  import bfa_pkg::*;

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 0;
  logic        in_ready;
  logic        opcode = 0;
  logic [15:0] request_bytes = '0;
  logic [14:0] payload_address = '0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [2:0]  status;
  logic [14:0] granted_address;
  logic [15:0] granted_bytes;

  alloc_scoreboard sb = new();
  bit quiet;
  int idle_cycles;

  best_fit_heap_allocator #(.HEAP_WORDS(4096)) u_top (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  function int draw_gap();
    return quiet ? 0 : $urandom_range(0, 11);
  endfunction

  task automatic send_item(logic op, logic [15:0] req, logic [14:0] pa);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid = 0;
      repeat (gap) @(negedge clk);
    end
    opcode = op;
    request_bytes = req;
    payload_address = pa;
    in_valid = 1;
    do @(posedge clk); while (!in_ready);
    sb.note_request(op, req, pa);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid = 0;
    while (sb.grant_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_limit(logic [15:0] v);
    drain();
    cfg_data = v;
    cfg_valid = 1;
    do @(posedge clk); while (!cfg_ready);
    sb.limit = v;
    @(negedge clk);
    cfg_valid = 0;
  endtask

  task automatic send_alloc(logic [15:0] req);
    send_item(OPC_ALLOC, req, 15'($urandom));
  endtask

  task automatic send_free(logic [14:0] pa);
    send_item(OPC_FREE, 16'($urandom), pa);
  endtask

  task automatic random_item();
    int r, p;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      r = $urandom_range(0, 99);
      if (r < 75) send_alloc(16'($urandom_range(1, 200)));
      else if (r < 93) send_alloc(16'($urandom_range(200, 2048)));
      else if (r < 97) send_alloc(16'($urandom_range(0, 32768)));
      else send_alloc(16'd0);
    end else if (r < 82 && sb.live.size() > 0) begin
      send_free(15'(sb.live[$urandom_range(0, sb.live.size() - 1)]));
    end else begin
      r = $urandom_range(0, 3);
      p = (sb.stale.size() > 0) ? sb.stale[$urandom_range(0, sb.stale.size() - 1)] : 0;
      if (r == 0 && p != 0 && sb.stale_safe(p)) send_free(15'(p));
      else if (r == 1) send_free(15'($urandom) | 15'd1);
      else if (r == 2 && sb.top < 32768)
        send_free(15'($urandom_range(sb.top > 0 ? sb.top : 1, 32767)));
      else send_free(15'd0);
    end
  endtask

  initial begin
    forever begin
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
        out_ready = 0;
        repeat (gap) @(negedge clk);
      end
      out_ready = 1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_grant(status, granted_address, granted_bytes);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= 20000) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    logic [15:0] limits[5];
    int a0, a1, a2, a3;
    limits = '{16'd32768, 16'd32, 16'($urandom_range(32, 32768)), 16'd32767, 16'd32768};
    idle_cycles = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 0;
    write_limit(limits[0]);

    send_alloc(16'd0);
    send_alloc(16'd1);
    send_alloc(16'd100);
    send_alloc(16'd40);
    send_alloc(16'd200);
    send_alloc(16'd24);
    a0 = sb.live[1]; a1 = sb.live[2]; a2 = sb.live[3]; a3 = sb.live[4];
    send_alloc(16'd32768);
    send_alloc(16'd32767);
    send_free(15'd0);
    send_free(15'(a0 + 3));
    send_free(15'h7FF8);
    send_free(15'(a1));
    send_free(15'(a0));
    send_free(15'(a1));
    send_free(15'(a0));
    send_alloc(16'd48);
    send_alloc(16'd17);
    send_free(15'(a2));
    send_free(15'(a3));
    send_free(15'(a3));
    send_free(15'h7FFF);
    send_alloc(16'hFFFF);
    drain();

    foreach (limits[ph]) begin
      if (ph > 0) write_limit(limits[ph]);
      for (int i = 0; i < 160; i++) begin
        if (i % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
        if (i == 80) drain();
        random_item();
      end
    end
    quiet = 0;
    drain();
    repeat (100) @(posedge clk);
    $display("checked %0d results: ok %0d, zero %0d, oom %0d, invalid %0d, double free %0d",
             sb.checked, sb.status_count[ST_OK], sb.status_count[ST_ZERO],
             sb.status_count[ST_OOM], sb.status_count[ST_INVALID], sb.status_count[ST_DFREE]);
    $display("limits 32..32768 applied over five phases; %0d mismatches", sb.mismatches);
    if (sb.mismatches == 0 && sb.grant_q.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end
endmodule
